>>> design/vcf_pkg.sv
`timescale 1ns / 1ps

package vcf_pkg;

  // Field widths
  localparam int unsigned DataW  = 8;
  localparam int unsigned LenW   = 32;
  localparam int unsigned OffW   = 48;
  localparam int unsigned CrcW   = 32;

  // Header is 1..5 varint bytes; a run holds at most header plus four CRC bytes
  localparam int unsigned HeadMax  = 5;
  localparam int unsigned TailLen  = 4;
  localparam int unsigned HeadCntW = 3;
  localparam int unsigned RunCntW  = 4;

  // Input item kinds (tuser)
  localparam logic ModeStart = 1'b0;
  localparam logic ModeData  = 1'b1;

  // CRC32C, reflected
  localparam logic [CrcW-1:0] CrcPoly   = 32'h82F6_3B78;
  localparam logic [CrcW-1:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] MaskDelta = 32'hA282_EAD8;

  // Record state kept between items
  typedef struct packed {
    logic [CrcW-1:0] crc;
    logic [LenW-1:0] bytes_left;
    logic            open;
  } rec_state_t;

  // Everything the result run of one item needs
  typedef struct packed {
    logic [HeadMax-1:0][DataW-1:0] head;    // varint bytes, or the payload byte
    logic [HeadCntW-1:0]           head_n;  // bytes used in head
    logic                          tail;    // masked CRC follows the head
    logic [CrcW-1:0]               mask;    // masked CRC, sent low byte first
    logic                          err;     // data item with no open record
    logic                          new_rec; // start item: record begins at cursor
    logic [RunCntW-1:0]            step;    // bytes added to the log
  } run_plan_t;

  // One byte through the CRC32C register, LSB first
  function automatic logic [CrcW-1:0] crc32c_fold(input logic [CrcW-1:0] crc,
                                                  input logic [DataW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-DataW){1'b0}}, b};
    for (int k = 0; k < DataW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Final xor, rotate right by 15, add the mask constant
  function automatic logic [CrcW-1:0] crc_mask(input logic [CrcW-1:0] crc);
    logic [CrcW-1:0] c;
    c = crc ^ CrcInit;
    return {c[14:0], c[CrcW-1:15]} + MaskDelta;
  endfunction

endpackage

>>> design/vcf_crc_step.sv
`timescale 1ns / 1ps

// One CRC32C byte step and the masked value of the result
module vcf_crc_step (
  input  logic [vcf_pkg::CrcW-1:0]  crc_i,
  input  logic [vcf_pkg::DataW-1:0] byte_i,
  input  logic                      fold_i,
  output logic [vcf_pkg::CrcW-1:0]  crc_o,
  output logic [vcf_pkg::CrcW-1:0]  mask_o
);
  import vcf_pkg::*;

  assign crc_o  = fold_i ? crc32c_fold(crc_i, byte_i) : crc_i;
  assign mask_o = crc_mask(crc_o);

endmodule

>>> design/vcf_run_build.sv
`timescale 1ns / 1ps

// Works out the result run of one item and the record state it leaves
module vcf_run_build (
  input  logic                       mode_i,
  input  logic [vcf_pkg::LenW-1:0]   len_i,
  input  logic [vcf_pkg::DataW-1:0]  byte_i,
  input  vcf_pkg::rec_state_t        state_i,
  output vcf_pkg::rec_state_t        state_o,
  output vcf_pkg::run_plan_t         plan_o
);
  import vcf_pkg::*;

  logic                is_start;
  logic                is_data;
  logic                is_err;
  logic [CrcW-1:0]     crc_next;
  logic [CrcW-1:0]     mask;
  logic [LenW-1:0]     left_dec;
  logic                data_end;
  logic [3:0]          more;      // varint byte i+1 exists
  logic [HeadCntW-1:0] nv;
  logic                tail;

  assign is_start = (mode_i == ModeStart);
  assign is_data  = (mode_i == ModeData) && state_i.open;
  assign is_err   = (mode_i == ModeData) && !state_i.open;

  // Start items compute the mask of an empty payload
  vcf_crc_step u_crc (
    .crc_i  (is_start ? CrcInit : state_i.crc),
    .byte_i (byte_i),
    .fold_i (is_data),
    .crc_o  (crc_next),
    .mask_o (mask)
  );

  assign left_dec = state_i.bytes_left - LenW'(1);
  assign data_end = (left_dec == '0);

  // Varint length
  assign more[0] = (len_i[LenW-1:7]  != '0);
  assign more[1] = (len_i[LenW-1:14] != '0);
  assign more[2] = (len_i[LenW-1:21] != '0);
  assign more[3] = (len_i[LenW-1:28] != '0);
  assign nv = HeadCntW'(1) + HeadCntW'(more[0]) + HeadCntW'(more[1])
            + HeadCntW'(more[2]) + HeadCntW'(more[3]);

  assign tail = is_start ? (len_i == '0) : (is_data && data_end);

  // Run plan
  always_comb begin
    plan_o = '0;
    if (is_start) begin
      plan_o.head[0] = {more[0], len_i[6:0]};
      plan_o.head[1] = {more[1], len_i[13:7]};
      plan_o.head[2] = {more[2], len_i[20:14]};
      plan_o.head[3] = {more[3], len_i[27:21]};
      plan_o.head[4] = {4'b0, len_i[31:28]};
      plan_o.head_n  = nv;
    end else begin
      plan_o.head[0] = is_err ? '0 : byte_i;
      plan_o.head_n  = HeadCntW'(1);
    end
    plan_o.tail    = tail;
    plan_o.mask    = mask;
    plan_o.err     = is_err;
    plan_o.new_rec = is_start;
    if (is_err) begin
      plan_o.step = '0;
    end else begin
      plan_o.step = RunCntW'(plan_o.head_n) + (tail ? RunCntW'(TailLen) : '0);
    end
  end

  // Next record state
  always_comb begin
    state_o = state_i;
    if (is_start) begin
      state_o.crc        = CrcInit;
      state_o.bytes_left = len_i;
      state_o.open       = (len_i != '0);
    end else if (is_data) begin
      state_o.crc        = data_end ? CrcInit : crc_next;
      state_o.bytes_left = left_dec;
      state_o.open       = !data_end;
    end
  end

endmodule

>>> design/varint_crc_record_framer.sv
`timescale 1ns / 1ps

// Record framer: a start item (tuser 0) opens a record and yields its length as a
// 1..5 byte little-endian varint; with length zero the four bytes of the masked
// CRC32C of the empty payload follow at once. Each data item (tuser 1) yields its
// payload byte, and the last payload byte of a record is followed by the four
// masked CRC bytes, low byte first. Every output byte carries the log offset of
// its record header; a data item with no open record yields one byte with the
// error bit set and is dropped. An item is worked out in the cycle it is taken and
// its run of results is held in the output register, one byte per cycle while
// m_axis_tready_i is high. A run holds one byte for a payload byte, five for the
// payload byte that ends its record, one for a stray data byte and one to five for
// a start item; the next item is taken in the cycle the last byte of the current
// run leaves. A write of cfg_wdata_i moves the log position of the next framed
// byte; write only while the block is idle.
module varint_crc_record_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: log position of the next byte
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // record_length[31:0], data_byte[39:32]
  input  logic        s_axis_tuser_i,   // mode
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // out_byte[7:0], record_start[55:8]
  output logic        m_axis_tlast_o,   // run_last
  output logic [1:0]  m_axis_tuser_o    // record_done[0], error_flag[1]
);
  import vcf_pkg::*;

  rec_state_t          state_q, state_d;
  run_plan_t           plan, run_q;
  logic [OffW-1:0]     cursor_q;
  logic [OffW-1:0]     start_q;
  logic [OffW-1:0]     run_start_q;
  logic                run_valid_q;
  logic [RunCntW-1:0]  run_idx_q;
  logic [RunCntW-1:0]  run_n;
  logic [RunCntW-1:0]  tail_idx;
  logic [HeadCntW-1:0] head_idx;
  logic                run_end;
  logic                in_acc;
  logic                out_acc;
  logic [DataW-1:0]    out_byte;

  // Item decode and next state
  vcf_run_build u_build (
    .mode_i  (s_axis_tuser_i),
    .len_i   (s_axis_tdata_i[LenW-1:0]),
    .byte_i  (s_axis_tdata_i[LenW+DataW-1:LenW]),
    .state_i (state_q),
    .state_o (state_d),
    .plan_o  (plan)
  );

  // Handshake
  assign run_n   = RunCntW'(run_q.head_n) + (run_q.tail ? RunCntW'(TailLen) : '0);
  assign run_end = (run_idx_q == run_n - RunCntW'(1));
  assign out_acc = run_valid_q && m_axis_tready_i;
  assign s_axis_tready_o = !run_valid_q || (run_end && m_axis_tready_i);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;

  // Record state, log cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= '{crc: CrcInit, bytes_left: '0, open: 1'b0};
      cursor_q <= '0;
      start_q  <= '0;
    end else if (cfg_we_i) begin
      cursor_q <= cfg_wdata_i;
    end else if (in_acc) begin
      state_q  <= state_d;
      cursor_q <= cursor_q + OffW'(plan.step);
      if (plan.new_rec) begin
        start_q <= cursor_q;
      end
    end
  end

  // Run register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_idx_q   <= '0;
    end else if (in_acc) begin
      run_valid_q <= 1'b1;
      run_idx_q   <= '0;
    end else if (out_acc) begin
      if (run_end) begin
        run_valid_q <= 1'b0;
      end else begin
        run_idx_q <= run_idx_q + RunCntW'(1);
      end
    end
  end

  // Run payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      run_q       <= plan;
      run_start_q <= plan.new_rec ? cursor_q : start_q;
    end
  end

  // Byte select: header bytes, then masked CRC low byte first
  assign tail_idx = run_idx_q - RunCntW'(run_q.head_n);
  assign head_idx = (run_idx_q < RunCntW'(run_q.head_n)) ? run_idx_q[HeadCntW-1:0] : '0;

  always_comb begin
    if (run_idx_q < RunCntW'(run_q.head_n)) begin
      out_byte = run_q.head[head_idx];
    end else begin
      out_byte = run_q.mask[{tail_idx[1:0], 3'b000} +: DataW];
    end
  end

  assign m_axis_tvalid_o   = run_valid_q;
  assign m_axis_tdata_o    = {run_start_q, out_byte};
  assign m_axis_tlast_o    = run_end;
  assign m_axis_tuser_o[0] = run_q.tail && run_end;
  assign m_axis_tuser_o[1] = run_q.err;

  // Checks
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> (run_idx_q < run_n))
    else $error("run index past run length");

  a_open_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.open |-> (state_q.bytes_left != '0))
    else $error("open record with no bytes left");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_valid_q && run_q.err) |-> (run_end && !run_q.tail))
    else $error("error run longer than one byte");

  a_no_take_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_valid_q && !run_end) |-> !s_axis_tready_o)
    else $error("input taken in the middle of a run");

  a_cursor_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_we_i) |=> (cursor_q == $past(cursor_q) + OffW'($past(plan.step))))
    else $error("cursor step mismatch");

endmodule
